>>> rtl/assert_macros.svh
// Assertion macros shared by the ternary bit-vector ALU modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define TBA_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define TBA_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

>>> rtl/tba_pkg.sv
// Types, codes and helper functions of the ternary bit-vector ALU
package tba_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int IDX_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);

  typedef logic [MAX_WIDTH-1:0] word_t;
  typedef logic [3:0]           action_t;
  typedef logic [1:0]           verdict_t;
  typedef logic [WIDTH_W-1:0]   width_t;
  typedef logic [IDX_W-1:0]     idx_t;

  localparam action_t ACT_AND  = 4'd0;
  localparam action_t ACT_OR   = 4'd1;
  localparam action_t ACT_ADD  = 4'd2;
  localparam action_t ACT_MUL  = 4'd3;
  localparam action_t ACT_UDIV = 4'd4;
  localparam action_t ACT_UREM = 4'd5;
  localparam action_t ACT_ULE  = 4'd6;
  localparam action_t ACT_SLE  = 4'd7;
  localparam action_t ACT_EQ   = 4'd8;

  localparam verdict_t VERDICT_FALSE   = 2'd0;
  localparam verdict_t VERDICT_TRUE    = 2'd1;
  localparam verdict_t VERDICT_UNKNOWN = 2'd2;

  typedef struct packed {
    logic any;
    idx_t idx;
  } tbit_t;

  typedef struct packed {
    tbit_t pa;
    tbit_t pb;
    tbit_t av;
    tbit_t bv;
  } tops_t;

  typedef struct packed {
    action_t action;
    word_t   ak;
    word_t   av;
    word_t   bk;
    word_t   bv;
    word_t   pa;
    word_t   pb;
    tops_t   tops;
  } s1_t;

  typedef struct packed {
    action_t  action;
    word_t    ak;
    word_t    av;
    word_t    bk;
    word_t    bv;
    word_t    add_rk;
    word_t    add_rv;
    tops_t    tops;
    logic     d_any;
    logic     a_gt;
    logic     ct;
    logic     cf;
    logic     sgn_known;
    logic     sgn_av;
    logic     sgn_bv;
    verdict_t eq_verdict;
  } s2_t;

  typedef struct packed {
    word_t    result_value;
    word_t    result_known;
    verdict_t verdict;
  } res_t;

  function automatic tbit_t top_bit(word_t x);
    tbit_t t;
    t = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      if (x[i]) begin
        t.any = 1'b1;
        t.idx = idx_t'(i);
      end
    end
    return t;
  endfunction

  // Fill every bit below the highest set bit
  function automatic word_t smear_down(word_t x);
    word_t s;
    s = x;
    for (int k = 1; k < MAX_WIDTH; k = k * 2) begin
      s = s | (s >> k);
    end
    return s;
  endfunction

  // Bits strictly above position k
  function automatic word_t mask_above(idx_t k);
    word_t s;
    s = {MAX_WIDTH{1'b1}} << k;
    return s << 1;
  endfunction

endpackage

>>> rtl/tba_if.sv
// Operand and result channel interfaces of the ternary bit-vector ALU
interface tba_in_if;
  logic             valid;
  logic             ready;
  tba_pkg::action_t action;
  tba_pkg::word_t   a_value;
  tba_pkg::word_t   a_known;
  tba_pkg::word_t   b_value;
  tba_pkg::word_t   b_known;

  modport source(output valid, action, a_value, a_known, b_value, b_known, input ready);
  modport sink(input valid, action, a_value, a_known, b_value, b_known, output ready);
endinterface

interface tba_out_if;
  logic              valid;
  logic              ready;
  tba_pkg::word_t    result_value;
  tba_pkg::word_t    result_known;
  tba_pkg::verdict_t verdict;

  modport source(output valid, result_value, result_known, verdict, input ready);
  modport sink(input valid, result_value, result_known, verdict, output ready);
endinterface

>>> rtl/tba_prep.sv
// First stage: operand masking and highest-bit encoding
module tba_prep (
  input  logic            clk,
  input  logic            rst,
  tba_in_if.sink          operands,
  input  tba_pkg::word_t  mask,
  output logic            out_valid,
  input  logic            out_ready,
  output tba_pkg::s1_t    out_data
);
  import tba_pkg::*;

  s1_t  data_next;
  logic advance;

  assign advance        = !out_valid || out_ready;
  assign operands.ready = advance;

  always_comb begin
    data_next        = '0;
    data_next.action = operands.action;
    data_next.ak     = operands.a_known & mask;
    data_next.av     = operands.a_value & data_next.ak;
    data_next.bk     = operands.b_known & mask;
    data_next.bv     = operands.b_value & data_next.bk;
    data_next.pa     = (~data_next.ak | data_next.av) & mask;
    data_next.pb     = (~data_next.bk | data_next.bv) & mask;
    data_next.tops.pa = top_bit(data_next.pa);
    data_next.tops.pb = top_bit(data_next.pb);
    data_next.tops.av = top_bit(data_next.av);
    data_next.tops.bv = top_bit(data_next.bv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && operands.valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> rtl/tba_core.sv
// Second stage: ternary carry adders, comparison scan and equality test
`include "assert_macros.svh"

module tba_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tba_pkg::s1_t    in_data,
  input  tba_pkg::word_t  mask,
  output logic            out_valid,
  input  logic            out_ready,
  output tba_pkg::s2_t    out_data
);
  import tba_pkg::*;

  s2_t   data_next;
  word_t sum_min;
  word_t sum_max;
  word_t cmin;
  word_t cmax;
  word_t range;
  word_t diff;
  word_t smear;
  word_t above;
  word_t sign_pos;
  word_t both_known;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    // lowest and highest possible carries: unknown bits as 0, then as 1
    sum_min    = in_data.av + in_data.bv;
    sum_max    = in_data.pa + in_data.pb;
    cmin       = sum_min ^ in_data.av ^ in_data.bv;
    cmax       = sum_max ^ in_data.pa ^ in_data.pb;
    both_known = in_data.ak & in_data.bk;

    range    = (in_data.action == ACT_SLE) ? (mask >> 1) : mask;
    diff     = both_known & (in_data.av ^ in_data.bv) & range;
    smear    = smear_down(diff);
    above    = range & ~smear;
    sign_pos = mask & ~(mask >> 1);

    data_next        = '0;
    data_next.action = in_data.action;
    data_next.ak     = in_data.ak;
    data_next.av     = in_data.av;
    data_next.bk     = in_data.bk;
    data_next.bv     = in_data.bv;
    data_next.tops   = in_data.tops;
    data_next.add_rk = both_known & ~(cmin ^ cmax);
    data_next.add_rv = (in_data.av ^ in_data.bv ^ cmin) & data_next.add_rk;
    data_next.d_any  = |diff;
    data_next.a_gt   = |(in_data.av & smear & ~(smear >> 1));
    data_next.ct     = |(((in_data.ak & ~in_data.av & ~in_data.bk)
                        | (~in_data.ak & in_data.bk & in_data.bv)
                        | (~in_data.ak & ~in_data.bk)) & above);
    data_next.cf     = |(((in_data.ak & in_data.av & ~in_data.bk)
                        | (~in_data.ak & in_data.bk & ~in_data.bv)
                        | (~in_data.ak & ~in_data.bk)) & above);
    data_next.sgn_known = |(both_known & sign_pos);
    data_next.sgn_av    = |(in_data.av & sign_pos);
    data_next.sgn_bv    = |(in_data.bv & sign_pos);

    if (|((in_data.av ^ in_data.bv) & both_known)) begin
      data_next.eq_verdict = VERDICT_FALSE;
    end else if (both_known == mask) begin
      data_next.eq_verdict = VERDICT_TRUE;
    end else begin
      data_next.eq_verdict = VERDICT_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

  `TBA_ASSERT_IMPL(a_add_known_from_operands, out_valid, (out_data.add_rk & ~(out_data.ak & out_data.bk)) == '0, "add result known where an operand bit is unknown")

endmodule

>>> rtl/tba_resolve.sv
// Third stage: per-operation result selection and output register
`include "assert_macros.svh"

module tba_resolve (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tba_pkg::s2_t    in_data,
  input  tba_pkg::word_t  mask,
  input  tba_pkg::width_t width,
  tba_out_if.source       results
);
  import tba_pkg::*;

  logic     valid;
  res_t     data;
  res_t     data_next;
  word_t    rk;
  word_t    rv;
  verdict_t verdict;
  verdict_t flow;
  width_t   bound;
  width_t   quot_top;
  idx_t     upper;

  assign in_ready = !valid || results.ready;

  always_comb begin
    bound    = width_t'(in_data.tops.pa.idx) + width_t'(in_data.tops.pb.idx) + width_t'(1);
    upper    = in_data.tops.pa.idx - in_data.tops.bv.idx;
    quot_top = width_t'(in_data.tops.pb.idx) + width_t'(upper) + width_t'(1);

    if (in_data.d_any && in_data.a_gt) begin
      flow = in_data.ct ? VERDICT_UNKNOWN : VERDICT_FALSE;
    end else begin
      flow = in_data.cf ? VERDICT_UNKNOWN : VERDICT_TRUE;
    end

    rk      = '0;
    rv      = '0;
    verdict = VERDICT_FALSE;
    unique case (in_data.action) inside
      ACT_AND: begin
        rk = (in_data.ak & in_data.bk) | (in_data.ak & ~in_data.av)
           | (in_data.bk & ~in_data.bv);
        rv = in_data.av & in_data.bv;
      end
      ACT_OR: begin
        rk = (in_data.ak & in_data.bk) | in_data.av | in_data.bv;
        rv = in_data.av | in_data.bv;
      end
      ACT_ADD: begin
        rk = in_data.add_rk;
        rv = in_data.add_rv;
      end
      ACT_MUL: begin
        if (!in_data.tops.pa.any || !in_data.tops.pb.any) begin
          rk = mask;
        end else if (bound < width) begin
          rk = mask & mask_above(bound[IDX_W-1:0]);
        end
      end
      ACT_UDIV, ACT_UREM: begin
        if (!in_data.tops.bv.any) begin
          rk = '0;
        end else if (!in_data.tops.pa.any) begin
          rk = mask;
        end else if (in_data.tops.pa.idx < in_data.tops.bv.idx) begin
          if (in_data.action == ACT_UDIV) begin
            rk = mask;
          end else begin
            rk = in_data.ak;
            rv = in_data.av;
          end
        end else if (in_data.action == ACT_UDIV) begin
          rk = mask & mask_above(upper);
          if (in_data.tops.av.any && (width_t'(in_data.tops.av.idx) == quot_top)) begin
            rk = rk | (word_t'(1) << upper);
            rv = word_t'(1) << upper;
          end
        end else begin
          rk = mask & mask_above(in_data.tops.pb.idx);
        end
      end
      ACT_ULE: begin
        verdict = flow;
      end
      ACT_SLE: begin
        if (!in_data.sgn_known) begin
          verdict = VERDICT_UNKNOWN;
        end else if (in_data.sgn_av && !in_data.sgn_bv) begin
          verdict = VERDICT_TRUE;
        end else if (!in_data.sgn_av && in_data.sgn_bv) begin
          verdict = VERDICT_FALSE;
        end else begin
          verdict = flow;
        end
      end
      ACT_EQ: begin
        verdict = in_data.eq_verdict;
      end
      default: begin
        verdict = VERDICT_UNKNOWN;
      end
    endcase

    data_next.result_known = rk & mask;
    data_next.result_value = rv & rk & mask;
    data_next.verdict      = verdict;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign results.valid        = valid;
  assign results.result_value = data.result_value;
  assign results.result_known = data.result_known;
  assign results.verdict      = data.verdict;

  `TBA_ASSERT_IMPL(a_known_within_width, results.valid, (results.result_known & ~mask) == '0, "known bit above operand width")
  `TBA_ASSERT_IMPL(a_value_within_known, results.valid, (results.result_value & ~results.result_known) == '0, "value bit set where result unknown")
  `TBA_ASSERT_IMPL(a_verdict_clears_result, results.valid && results.verdict != VERDICT_FALSE, results.result_known == '0, "verdict given with known result bits")
  `TBA_ASSERT_IMPL(a_verdict_code, results.valid, results.verdict <= VERDICT_UNKNOWN, "verdict code out of range")

endmodule

>>> rtl/ternary_bitvector_alu.sv
// Top level of the ternary bit-vector ALU: configuration port and stage chain
//
// Ternary bit-vector ALU: each operand arrives as value bits and known-bit
// masks, and the block returns the known-bits abstraction of and, or, add,
// multiply, udiv and urem, or a false/true/unknown verdict for ule, sle and
// eq. It takes one transaction every cycle while the output is not stalled.
// Its three register stages are operand masking with highest-bit encoding,
// the pair of 64-bit carry adders with the comparison scan, and the result
// select that also serves as output register. Backpressure stalls the stages
// holding data; empty stages keep filling. operand_width (byte address 0) sets
// the active bit count, 0 acting as 1 and values above 64 as 64; write it only
// while no transaction is in flight.
module ternary_bitvector_alu (
  input  logic        clk,
  input  logic        rst,
  tba_in_if.sink      operands,
  tba_out_if.source   results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tba_pkg::*;

  localparam int   APB_DATA_W        = 32;
  localparam logic REG_OPERAND_WIDTH = 1'b0;

  width_t operand_width;
  width_t width;
  word_t  mask;
  logic   cfg_write;
  logic   reg_index;

  logic   s1_valid;
  logic   s1_ready;
  s1_t    s1_data;
  logic   s2_valid;
  logic   s2_ready;
  s2_t    s2_data;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == REG_OPERAND_WIDTH)
                   ? {{(APB_DATA_W - WIDTH_W){1'b0}}, operand_width} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_width <= width_t'(32);
    end else if (cfg_write && reg_index == REG_OPERAND_WIDTH) begin
      operand_width <= pwdata[WIDTH_W-1:0];
    end
  end

  always_comb begin
    if (operand_width == '0) begin
      width = width_t'(1);
    end else if (operand_width > width_t'(MAX_WIDTH)) begin
      width = width_t'(MAX_WIDTH);
    end else begin
      width = operand_width;
    end
    mask = {MAX_WIDTH{1'b1}} >> (width_t'(MAX_WIDTH) - width);
  end

  tba_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .operands  (operands),
    .mask      (mask),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  tba_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .mask      (mask),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  tba_resolve u_resolve (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_ready (s2_ready),
    .in_data  (s2_data),
    .mask     (mask),
    .width    (width),
    .results  (results)
  );

endmodule
